[src/pbcc_pkg.sv]
// pbcc_pkg: shared types, constants and helpers of the power button and
// command controller. Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package pbcc_pkg;

	// line buffer sizing
	localparam int LINE_CAPACITY = 10;
	localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
	localparam int IDX_W = $clog2(LINE_CAPACITY);

	// counter and register widths
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BANK = 2'd3;

	// register reset values
	localparam logic [CNT_W-1:0] SHORT_PRESS_RESET = 16'd30;
	localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd300;
	localparam logic [CNT_W-1:0] IDLE_LIMIT_RESET = 16'd3000;
	localparam logic DEFAULT_BANK_RESET = 1'b0;

	// item kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	// line end characters
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// responses
	localparam logic [1:0] RESP_NONE = 2'd0;
	localparam logic [1:0] RESP_OK = 2'd1;
	localparam logic [1:0] RESP_ERROR = 2'd2;

	// command codes
	localparam logic [3:0] CMD_NONE = 4'd0;
	localparam logic [3:0] CMD_POWERDOWN = 4'd1;
	localparam logic [3:0] CMD_POWERUP = 4'd2;
	localparam logic [3:0] CMD_ROML = 4'd3;
	localparam logic [3:0] CMD_ROMH = 4'd4;
	localparam logic [3:0] CMD_DEFROML = 4'd5;
	localparam logic [3:0] CMD_DEFROMH = 4'd6;
	localparam logic [3:0] CMD_VERSION = 4'd7;
	localparam logic [3:0] CMD_HELP = 4'd8;

	// command keyword table, lower case, padded with zero bytes
	localparam int NUM_WORDS = 8;
	localparam int WORD_MAX = 9;
	localparam logic [0:NUM_WORDS-1][0:WORD_MAX-1][7:0] WORD_TEXT = '{
		'{"p", "o", "w", "e", "r", "d", "o", "w", "n"},
		'{"p", "o", "w", "e", "r", "u", "p", 8'h00, 8'h00},
		'{"r", "o", "m", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "o", "m", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "e", "f", "r", "o", "m", "l", 8'h00, 8'h00},
		'{"d", "e", "f", "r", "o", "m", "h", 8'h00, 8'h00},
		'{"v", "e", "r", "s", "i", "o", "n", 8'h00, 8'h00},
		'{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [0:NUM_WORDS-1][LEN_W-1:0] WORD_LEN = '{
		LEN_W'(9), LEN_W'(7), LEN_W'(4), LEN_W'(4),
		LEN_W'(7), LEN_W'(7), LEN_W'(7), LEN_W'(4)
	};
	localparam logic [0:NUM_WORDS-1][3:0] WORD_CODE = '{
		CMD_POWERDOWN, CMD_POWERUP, CMD_ROML, CMD_ROMH,
		CMD_DEFROML, CMD_DEFROMH, CMD_VERSION, CMD_HELP
	};

	// one input beat
	typedef struct packed {
		logic       req_type;
		logic       button_down;
		logic [7:0] rx_byte;
	} item_t;

	// one result beat
	typedef struct packed {
		logic       power_on;
		logic       rom_pin;
		logic       hibernate;
		logic       echo_valid;
		logic [7:0] echo_char;
		logic       bell;
		logic [1:0] response;
		logic [3:0] command_code;
		logic       default_write_valid;
		logic       default_write_value;
	} result_t;

	// register write from the configuration port
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// upper case letters fold to lower case
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

[src/pbcc_cmd_match.sv]
// pbcc_cmd_match: compares the buffered line, ignoring case, against the
// keyword table. Depends on pbcc_pkg.
`timescale 1ns / 1ps

module pbcc_cmd_match (
	input  logic [7:0]                 line [pbcc_pkg::LINE_CAPACITY],
	input  logic [pbcc_pkg::LEN_W-1:0] line_len,
	output logic [3:0]                 code
);

	logic [pbcc_pkg::NUM_WORDS-1:0] hit;

	// per keyword: length equal and every used character equal
	always_comb begin
		for (int k = 0; k < pbcc_pkg::NUM_WORDS; k++) begin
			hit[k] = (line_len == pbcc_pkg::WORD_LEN[k]);
			for (int i = 0; i < pbcc_pkg::WORD_MAX; i++) begin
				if (pbcc_pkg::LEN_W'(i) < pbcc_pkg::WORD_LEN[k] &&
					pbcc_pkg::fold_case(line[i]) != pbcc_pkg::WORD_TEXT[k][i]) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	// first keyword in table order wins
	always_comb begin
		code = pbcc_pkg::CMD_NONE;
		for (int k = pbcc_pkg::NUM_WORDS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				code = pbcc_pkg::WORD_CODE[k];
			end
		end
	end

endmodule

[src/pbcc_engine.sv]
// pbcc_engine: controller state (power, ROM bank, counters, line buffer,
// settings) and the next-state and result logic for one beat.
// Depends on pbcc_pkg and pbcc_cmd_match.
`timescale 1ns / 1ps

module pbcc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  pbcc_pkg::cfg_wr_t cfg,
	input  logic              step,
	input  pbcc_pkg::item_t   item,
	output pbcc_pkg::result_t result
);

	localparam int CNT_W = pbcc_pkg::CNT_W;
	localparam int LEN_W = pbcc_pkg::LEN_W;
	localparam int IDX_W = pbcc_pkg::IDX_W;

	// settings
	logic [CNT_W-1:0] short_press_q;
	logic [CNT_W-1:0] long_press_q;
	logic [CNT_W-1:0] idle_limit_q;

	// controller state
	logic             power_q, power_n;
	logic             choice_q, choice_n;
	logic             pin_q, pin_n;
	logic             stored_q, stored_n;
	logic [CNT_W-1:0] press_q, press_n;
	logic [CNT_W-1:0] idle_q, idle_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [7:0]       line_q [pbcc_pkg::LINE_CAPACITY];
	logic             store_en;

	logic [3:0] match_code;

	pbcc_cmd_match u_match (
		.line     (line_q),
		.line_len (len_q),
		.code     (match_code)
	);

	// next state and result of the beat in flight
	always_comb begin
		power_n = power_q;
		choice_n = choice_q;
		pin_n = pin_q;
		stored_n = stored_q;
		press_n = press_q;
		idle_n = idle_q;
		len_n = len_q;
		store_en = 1'b0;
		result = '0;
		if (item.req_type == pbcc_pkg::REQ_TICK) begin
			if (item.button_down) begin
				if (press_q != '1) begin
					press_n = press_q + CNT_W'(1);
				end
				idle_n = '0;
			end else begin
				if (power_q) begin
					if (press_q > long_press_q) begin
						power_n = 1'b0;
						pin_n = 1'b0;
					end
				end else if (press_q > short_press_q) begin
					power_n = 1'b1;
					pin_n = pin_q | choice_q;
				end
				press_n = '0;
				if (idle_q != '1) begin
					idle_n = idle_q + CNT_W'(1);
				end
				// idle timeout while off: hibernate and reinitialize
				if (!power_n && idle_n > idle_limit_q) begin
					result.hibernate = 1'b1;
					idle_n = '0;
					choice_n = stored_q;
					pin_n = 1'b0;
				end
			end
		end else if (item.rx_byte == pbcc_pkg::CHAR_CR ||
			item.rx_byte == pbcc_pkg::CHAR_LF) begin
			// line end runs the command
			len_n = '0;
			result.command_code = match_code;
			result.response = (match_code == pbcc_pkg::CMD_NONE) ?
				pbcc_pkg::RESP_ERROR : pbcc_pkg::RESP_OK;
			case (match_code)
				pbcc_pkg::CMD_POWERDOWN: begin
					power_n = 1'b0;
					pin_n = 1'b0;
				end
				pbcc_pkg::CMD_POWERUP: begin
					power_n = 1'b1;
					pin_n = pin_q | choice_q;
				end
				pbcc_pkg::CMD_ROML: begin
					choice_n = 1'b0;
					pin_n = 1'b0;
				end
				pbcc_pkg::CMD_ROMH: begin
					choice_n = 1'b1;
					pin_n = 1'b1;
				end
				pbcc_pkg::CMD_DEFROML: begin
					stored_n = 1'b0;
					result.default_write_valid = 1'b1;
					result.default_write_value = 1'b0;
				end
				pbcc_pkg::CMD_DEFROMH: begin
					stored_n = 1'b1;
					result.default_write_valid = 1'b1;
					result.default_write_value = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (len_q < LEN_W'(pbcc_pkg::LINE_CAPACITY)) begin
			// room left: store and echo
			store_en = 1'b1;
			len_n = len_q + LEN_W'(1);
			result.echo_valid = 1'b1;
			result.echo_char = item.rx_byte;
		end else begin
			result.bell = 1'b1;
		end
		result.power_on = power_n;
		result.rom_pin = pin_n;
	end

	// state registers, settings and bank loads from the register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_press_q <= pbcc_pkg::SHORT_PRESS_RESET;
			long_press_q <= pbcc_pkg::LONG_PRESS_RESET;
			idle_limit_q <= pbcc_pkg::IDLE_LIMIT_RESET;
			power_q <= 1'b0;
			choice_q <= pbcc_pkg::DEFAULT_BANK_RESET;
			pin_q <= 1'b0;
			stored_q <= pbcc_pkg::DEFAULT_BANK_RESET;
			press_q <= '0;
			idle_q <= '0;
			len_q <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				pbcc_pkg::REG_SHORT_PRESS: short_press_q <= cfg.data[CNT_W-1:0];
				pbcc_pkg::REG_LONG_PRESS: long_press_q <= cfg.data[CNT_W-1:0];
				pbcc_pkg::REG_IDLE_LIMIT: idle_limit_q <= cfg.data[CNT_W-1:0];
				pbcc_pkg::REG_DEFAULT_BANK: begin
					stored_q <= cfg.data[0];
					choice_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end else if (step) begin
			power_q <= power_n;
			choice_q <= choice_n;
			pin_q <= pin_n;
			stored_q <= stored_n;
			press_q <= press_n;
			idle_q <= idle_n;
			len_q <= len_n;
		end
	end

	// line buffer, no reset: only entries below the length are read
	always_ff @(posedge clk) begin
		if (step && store_en) begin
			line_q[len_q[IDX_W-1:0]] <= item.rx_byte;
		end
	end

endmodule

[src/power_button_and_command_controller_unit.sv]
// power_button_and_command_controller_unit: top level with the input
// register, the result register and the beat handshakes.
// Depends on pbcc_pkg and pbcc_engine.
`timescale 1ns / 1ps

// Usage:
// Input beats are either a timer tick (req_type 0, button_down holds the
// key level) or a received serial byte (req_type 1, rx_byte). Every input
// beat gives exactly one result beat with the power and ROM pin levels after
// the beat, a hibernate pulse, the echo or bell, and the command response.
// Both channels use valid and ready. Settings are written through cfg_we,
// cfg_index and cfg_data while no beat is in flight; a write takes effect
// at once.
// A beat is held in the input register, where the keyword compare and
// next-state logic run, and then in the result register, which drives
// out_valid. Throughput is one beat per cycle while the receiver keeps
// out_ready high.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat; after that in_ready drops until out_ready.
// Reset clears both registers, powers off, loads the default ROM bank and
// restores the register defaults; the line buffer comes up empty.
module power_button_and_command_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic                            button_down,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            power_on,
	output logic                            rom_pin,
	output logic                            hibernate,
	output logic                            echo_valid,
	output logic [7:0]                      echo_char,
	output logic                            bell,
	output logic [1:0]                      response,
	output logic [3:0]                      command_code,
	output logic                            default_write_valid,
	output logic                            default_write_value,
	input  logic                            cfg_we,
	input  logic [pbcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbcc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                valid_s1;
	pbcc_pkg::item_t     item_s1;
	logic                valid_s2;
	pbcc_pkg::result_t   result_s2;
	pbcc_pkg::result_t   result_c;
	pbcc_pkg::cfg_wr_t   cfg;
	logic                advance;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	// stage 1 moves on when the result register is free or its beat is being taken
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	pbcc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.result (result_c)
	);

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{req_type: req_type, button_down: button_down, rx_byte: rx_byte};
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	// result beat ports
	assign out_valid = valid_s2;
	assign power_on = result_s2.power_on;
	assign rom_pin = result_s2.rom_pin;
	assign hibernate = result_s2.hibernate;
	assign echo_valid = result_s2.echo_valid;
	assign echo_char = result_s2.echo_char;
	assign bell = result_s2.bell;
	assign response = result_s2.response;
	assign command_code = result_s2.command_code;
	assign default_write_valid = result_s2.default_write_valid;
	assign default_write_value = result_s2.default_write_value;

	// hibernate only ever goes out while powered off
	a_hib_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hibernate |-> !power_on)
		else $error("hibernate while powered on");

	// ok carries a command, error carries none
	a_resp_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && response != pbcc_pkg::RESP_NONE |->
		((response == pbcc_pkg::RESP_OK) == (command_code != pbcc_pkg::CMD_NONE)))
		else $error("response and command code disagree");

	// a default write comes only from the default bank commands
	a_def_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && default_write_valid |->
		(command_code == pbcc_pkg::CMD_DEFROML || command_code == pbcc_pkg::CMD_DEFROMH))
		else $error("default write without its command");

	// a beat in stage 1 that cannot move keeps the result register full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> valid_s2 && !out_ready)
		else $error("stage 1 stalled with the result register free");

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for power_button_and_command_controller_unit.
// Drives tick and byte beats with random gaps, predicts every result beat and
// compares it as a whole beat. Depends on pbcc_pkg and the unit under test.
`timescale 1ns / 1ps

module testbench;
	import pbcc_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_LIMIT = 10;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// block ports, all driven to known values from time zero
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  req_type = 1'b0;
	logic                  button_down = 1'b0;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  power_on;
	logic                  rom_pin;
	logic                  hibernate;
	logic                  echo_valid;
	logic [7:0]            echo_char;
	logic                  bell;
	logic [1:0]            response;
	logic [3:0]            command_code;
	logic                  default_write_valid;
	logic                  default_write_value;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	power_button_and_command_controller_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.button_down(button_down),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power_on(power_on),
		.rom_pin(rom_pin),
		.hibernate(hibernate),
		.echo_valid(echo_valid),
		.echo_char(echo_char),
		.bell(bell),
		.response(response),
		.command_code(command_code),
		.default_write_valid(default_write_valid),
		.default_write_value(default_write_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// supervisor settings as the block should hold them
	logic [CNT_W-1:0] cfg_short = SHORT_PRESS_RESET;
	logic [CNT_W-1:0] cfg_long = LONG_PRESS_RESET;
	logic [CNT_W-1:0] cfg_idle = IDLE_LIMIT_RESET;

	// supervisor state as the block should hold it
	logic             pwr = 1'b0;
	logic             rom_sel = DEFAULT_BANK_RESET;
	logic             pin_lvl = 1'b0;
	logic             def_bank = DEFAULT_BANK_RESET;
	logic [CNT_W-1:0] press_ticks = '0;
	logic [CNT_W-1:0] idle_ticks = '0;
	logic [7:0]       line_buf [LINE_CAPACITY];
	int               line_len = 0;

	// command keywords and their codes
	string      cmd_words [NUM_WORDS] = '{"powerdown", "powerup", "roml", "romh",
		"defroml", "defromh", "version", "help"};
	logic [3:0] cmd_codes [NUM_WORDS] = '{CMD_POWERDOWN, CMD_POWERUP, CMD_ROML,
		CMD_ROMH, CMD_DEFROML, CMD_DEFROMH, CMD_VERSION, CMD_HELP};

	// stimulus and scoreboard
	item_t   pending_items [$];
	result_t predicted_results [$];
	int      items_queued = 0;
	int      fail_count = 0;
	int      quiet_cycles = 0;
	bit      no_idle = 1'b0;
	bit      beat_taken = 1'b0;
	int      send_gap = 0;
	int      hold_off = 0;
	int      drv_calm = 0;
	int      rcv_calm = 0;
	item_t   drive_item;
	item_t   took_item;
	result_t seen;
	result_t want;

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return c + 8'h20;
		end
		return c;
	endfunction

	// case-insensitive compare of the held line against one keyword
	function automatic bit line_is(input string w);
		int i;
		if (line_len != w.len()) begin
			return 1'b0;
		end
		for (i = 0; i < line_len; i++) begin
			if (lower_ascii(line_buf[i]) != 8'(w[i])) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// advance the supervisor by one beat and return the result it gives
	function automatic result_t step_supervisor(input item_t it);
		result_t r;
		int k;
		r = '0;
		if (it.req_type == REQ_TICK) begin
			if (it.button_down) begin
				if (press_ticks != '1) begin
					press_ticks++;
				end
				idle_ticks = '0;
			end else begin
				// release decides on press length, then idle timing
				if (pwr) begin
					if (press_ticks > cfg_long) begin
						pwr = 1'b0;
						pin_lvl = 1'b0;
					end
				end else if (press_ticks > cfg_short) begin
					pwr = 1'b1;
					pin_lvl = pin_lvl | rom_sel;
				end
				press_ticks = '0;
				if (idle_ticks != '1) begin
					idle_ticks++;
				end
				if (!pwr && idle_ticks > cfg_idle) begin
					r.hibernate = 1'b1;
					idle_ticks = '0;
					rom_sel = def_bank;
					pin_lvl = 1'b0;
				end
			end
		end else if (it.rx_byte == CHAR_LF || it.rx_byte == CHAR_CR) begin
			// line end runs the line as a command
			r.command_code = CMD_NONE;
			for (k = 0; k < NUM_WORDS; k++) begin
				if (r.command_code == CMD_NONE && line_is(cmd_words[k])) begin
					r.command_code = cmd_codes[k];
				end
			end
			line_len = 0;
			r.response = (r.command_code == CMD_NONE) ? RESP_ERROR : RESP_OK;
			case (r.command_code)
				CMD_POWERDOWN: begin
					pwr = 1'b0;
					pin_lvl = 1'b0;
				end
				CMD_POWERUP: begin
					pwr = 1'b1;
					pin_lvl = pin_lvl | rom_sel;
				end
				CMD_ROML: begin
					rom_sel = 1'b0;
					pin_lvl = 1'b0;
				end
				CMD_ROMH: begin
					rom_sel = 1'b1;
					pin_lvl = 1'b1;
				end
				CMD_DEFROML: begin
					def_bank = 1'b0;
					r.default_write_valid = 1'b1;
					r.default_write_value = 1'b0;
				end
				CMD_DEFROMH: begin
					def_bank = 1'b1;
					r.default_write_valid = 1'b1;
					r.default_write_value = 1'b1;
				end
				default: ;
			endcase
		end else if (line_len < LINE_CAPACITY) begin
			line_buf[line_len] = it.rx_byte;
			line_len++;
			r.echo_valid = 1'b1;
			r.echo_char = it.rx_byte;
		end else begin
			r.bell = 1'b1;
		end
		r.power_on = pwr;
		r.rom_pin = pin_lvl;
		return r;
	endfunction

	function automatic string beat_text(input result_t r);
		return $sformatf(
			"pwr %0d pin %0d hib %0d echo %0d/%02h bell %0d resp %0d cmd %0d dw %0d/%0d",
			r.power_on, r.rom_pin, r.hibernate, r.echo_valid, r.echo_char, r.bell,
			r.response, r.command_code, r.default_write_valid, r.default_write_value);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// gap length: mostly none or short, a few long, with calm stretches
	function automatic int pick_gap(inout int calm);
		int roll;
		if (no_idle) begin
			return 0;
		end
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 55) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// stimulus builders
	function automatic void push_tick(input logic held);
		item_t it;
		it.req_type = REQ_TICK;
		it.button_down = held;
		it.rx_byte = 8'($urandom);
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		item_t it;
		it.req_type = REQ_BYTE;
		it.button_down = 1'($urandom);
		it.rx_byte = b;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			push_byte(8'(s[i]));
		end
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CHAR_LF || b == CHAR_CR);
		return b;
	endfunction

	function automatic logic [7:0] line_end();
		return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
	endfunction

	function automatic void add_press(input int held);
		int i;
		for (i = 0; i < held; i++) begin
			push_tick(1'b1);
		end
		push_tick(1'b0);
	endfunction

	function automatic void add_idle(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			push_tick(1'b0);
		end
	endfunction

	function automatic int near_limit(input int x);
		int v;
		v = x + $urandom_range(0, 2) - 1;
		return (v < 0) ? 0 : v;
	endfunction

	// press lengths cluster around the two thresholds
	function automatic int pick_hold();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return near_limit(int'(cfg_short));
			2: return near_limit(int'(cfg_long));
			default: return $urandom_range(0, int'(cfg_long) + 5);
		endcase
	endfunction

	// keyword in random case, sometimes damaged
	function automatic void add_command_line();
		logic [7:0] text [$];
		string w;
		int i, pos, mode;
		logic [7:0] c;
		w = cmd_words[$urandom_range(0, NUM_WORDS - 1)];
		for (i = 0; i < w.len(); i++) begin
			c = 8'(w[i]);
			if ($urandom_range(0, 1)) begin
				c = c - 8'h20;
			end
			text.push_back(c);
		end
		mode = $urandom_range(0, 9);
		pos = $urandom_range(0, text.size() - 1);
		if (mode == 7) begin
			void'(text.pop_back());
		end else if (mode == 8) begin
			text.push_back(text_byte());
		end else if (mode == 9) begin
			text[pos] = $urandom_range(0, 1) ? 8'h00 : text_byte();
		end
		for (i = 0; i < text.size(); i++) begin
			push_byte(text[i]);
		end
		push_byte(line_end());
	endfunction

	// lines around the buffer size, the longer ones ring the bell
	function automatic void add_long_line();
		int i, n;
		n = $urandom_range(LINE_CAPACITY - 1, LINE_CAPACITY + 4);
		for (i = 0; i < n; i++) begin
			push_byte(text_byte());
		end
		push_byte(line_end());
	endfunction

	function automatic void add_random_traffic(input int budget);
		int start_count, pick, n, i;
		start_count = items_queued;
		while (items_queued - start_count < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				add_command_line();
			end else if (pick < 50) begin
				add_press(pick_hold());
			end else if (pick < 62) begin
				add_idle($urandom_range(1, int'(cfg_idle) + 3));
			end else if (pick < 72) begin
				add_long_line();
			end else if (pick < 80) begin
				push_byte(line_end());
			end else begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 1)) begin
						push_byte(8'($urandom_range(0, 255)));
					end else begin
						push_tick(1'($urandom));
					end
				end
			end
		end
	endfunction

	// register write, mirrored into the expected settings
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SHORT_PRESS: cfg_short = val;
			REG_LONG_PRESS: cfg_long = val;
			REG_IDLE_LIMIT: cfg_idle = val;
			REG_DEFAULT_BANK: begin
				def_bank = val[0];
				rom_sel = val[0];
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input int short_v, input int long_v, input int idle_v, input bit bank);
		write_reg(REG_SHORT_PRESS, CFG_DATA_W'(short_v));
		write_reg(REG_LONG_PRESS, CFG_DATA_W'(long_v));
		write_reg(REG_IDLE_LIMIT, CFG_DATA_W'(idle_v));
		write_reg(REG_DEFAULT_BANK, {15'($urandom), bank});
	endtask

	// wait until every queued beat is sent and every result has come back
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (pending_items.size() != 0 || in_valid || predicted_results.size() != 0);
	endtask

	// input driver: next beat at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beat_taken)) begin
			beat_taken = 1'b0;
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_items.size() != 0) begin
				drive_item = pending_items.pop_front();
				req_type <= drive_item.req_type;
				button_down <= drive_item.button_down;
				rx_byte <= drive_item.rx_byte;
				in_valid <= 1'b1;
				send_gap = pick_gap(drv_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver stalls at random
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else begin
			out_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				hold_off = pick_gap(rcv_calm);
			end
		end
	end

	// monitor: predict on input beats, check output beats, watch for hangs
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				took_item = {req_type, button_down, rx_byte};
				predicted_results.push_back(step_supervisor(took_item));
				beat_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				seen = {power_on, rom_pin, hibernate, echo_valid, echo_char, bell, response,
					command_code, default_write_valid, default_write_value};
				if (predicted_results.size() == 0) begin
					note_failure({"result beat with none expected: ", beat_text(seen)});
				end else begin
					want = predicted_results.pop_front();
					if (seen !== want) begin
						note_failure({"mismatch\n  expected ", beat_text(want),
							"\n  actual   ", beat_text(seen)});
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: case folding, power and bank commands while off, nul and empty lines
		push_tick(1'b1);
		push_tick(1'b0);
		push_text("RoMh");
		push_byte(CHAR_CR);
		push_text("POWERUP");
		push_byte(CHAR_LF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CHAR_CR);
		push_byte(CHAR_LF);
		push_text("defromh");
		push_byte(CHAR_CR);
		wait_drained();

		// small thresholds
		write_all(3, 6, 10, 1'b1);
		add_random_traffic(230);
		wait_drained();

		// all thresholds at zero
		write_all(0, 0, 0, 1'b0);
		add_random_traffic(150);
		wait_drained();

		// medium thresholds
		write_all(20, 40, 50, 1'($urandom));
		add_random_traffic(220);
		wait_drained();

		// top of range: thresholds out of reach, a short run without gaps
		write_all(16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1);
		no_idle = 1'b1;
		push_byte(CHAR_LF);
		push_text("powerup");
		push_byte(CHAR_CR);
		add_press(5);
		add_idle(8);
		push_text("ROMl");
		push_byte(CHAR_LF);
		wait_drained();
		no_idle = 1'b0;

		repeat (10) @(posedge clk);
		if (predicted_results.size() != 0) begin
			note_failure("results still expected at end of run");
		end
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
